// File: rtl/clnw_pkg.sv
`default_nettype none

package clnw_pkg;

  localparam int COLUMNS_PER_ROW = 16;
  localparam int ROW_COUNT = 2;

  // The column register must hold the row length itself and any locate column.
  localparam int COL_MAX = (COLUMNS_PER_ROW > 15) ? COLUMNS_PER_ROW : 15;
  localparam int COL_W = $clog2(COL_MAX + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int INIT_NIBBLES = 12;
  localparam int IDX_W = $clog2(INIT_NIBBLES);

  localparam logic [1:0] CMD_INIT   = 2'd0;
  localparam logic [1:0] CMD_LOCATE = 2'd1;
  localparam logic [1:0] CMD_CHAR   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam logic [7:0] BYTE_CLEAR   = 8'h01;
  localparam logic [7:0] ADDR_CMD     = 8'h80;
  localparam logic [7:0] ROW1_OFFSET  = 8'h40;
  localparam logic [7:0] ADDR_MASK    = 8'h7F;

  localparam logic [4:0] WAIT_NONE  = 5'd0;
  localparam logic [4:0] WAIT_CLEAR = 5'd2;
  localparam logic [4:0] WAIT_INIT  = 5'd20;

  // One queued job: an optional re-address byte followed by the main byte,
  // or the fixed initialisation sequence.
  typedef struct packed {
    logic       is_init;
    logic       has_pre;
    logic [7:0] pre_byte;
    logic [7:0] main_byte;
    logic       main_rs;
    logic [4:0] main_wait;
  } desc_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic [4:0] wait_ms;
  } init_nib_t;

  function automatic init_nib_t init_nibble(input logic [IDX_W-1:0] idx);
    init_nib_t r;
    unique case (idx)
      4'd0:    r = '{nibble: 4'h3, wait_ms: WAIT_INIT};
      4'd1:    r = '{nibble: 4'h3, wait_ms: WAIT_INIT};
      4'd2:    r = '{nibble: 4'h3, wait_ms: WAIT_INIT};
      4'd3:    r = '{nibble: 4'h2, wait_ms: WAIT_INIT};
      4'd4:    r = '{nibble: 4'h2, wait_ms: WAIT_NONE};
      4'd5:    r = '{nibble: 4'h8, wait_ms: WAIT_NONE};
      4'd6:    r = '{nibble: 4'h0, wait_ms: WAIT_NONE};
      4'd7:    r = '{nibble: 4'hC, wait_ms: WAIT_NONE};
      4'd8:    r = '{nibble: 4'h0, wait_ms: WAIT_NONE};
      4'd9:    r = '{nibble: 4'h1, wait_ms: WAIT_CLEAR};
      4'd10:   r = '{nibble: 4'h0, wait_ms: WAIT_NONE};
      4'd11:   r = '{nibble: 4'h6, wait_ms: WAIT_INIT};
      default: r = '{nibble: 4'h0, wait_ms: WAIT_NONE};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] addr_byte(input logic [COL_W-1:0] col, input logic row);
    logic [7:0] sum;
    sum = 8'(col) + (row ? ROW1_OFFSET : 8'h00);
    return ADDR_CMD | (sum & ADDR_MASK);
  endfunction

  function automatic logic next_row(input logic row);
    logic [1:0] t;
    t = {1'b0, row} + 2'd1;
    return (t >= 2'(ROW_COUNT)) ? 1'b0 : t[0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/clnw_front.sv
`default_nettype none

module clnw_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [1:0]         command,
  input  wire logic [3:0]         column,
  input  wire logic               row,
  input  wire logic [7:0]         char_code,
  output clnw_pkg::desc_t         desc
);

  logic [clnw_pkg::COL_W-1:0] col_r, col_nxt;
  logic                       row_r, row_nxt;

  logic                       wrap;
  logic [clnw_pkg::COL_W-1:0] c1;
  logic                       r1;
  logic                       loc_row;

  always_comb begin
    wrap    = (col_r >= clnw_pkg::COL_W'(clnw_pkg::COLUMNS_PER_ROW));
    c1      = wrap ? '0 : col_r;
    r1      = wrap ? clnw_pkg::next_row(row_r) : row_r;
    loc_row = (2'({1'b0, row}) >= 2'(clnw_pkg::ROW_COUNT)) ? 1'b0 : row;

    col_nxt = col_r;
    row_nxt = row_r;

    desc.is_init   = 1'b0;
    desc.has_pre   = 1'b0;
    desc.pre_byte  = clnw_pkg::addr_byte('0, r1);
    desc.main_byte = clnw_pkg::BYTE_CLEAR;
    desc.main_rs   = 1'b0;
    desc.main_wait = clnw_pkg::WAIT_NONE;

    unique case (command)
      clnw_pkg::CMD_INIT: begin
        desc.is_init = 1'b1;
        col_nxt = '0;
        row_nxt = 1'b0;
      end
      clnw_pkg::CMD_LOCATE: begin
        desc.main_byte = clnw_pkg::addr_byte(clnw_pkg::COL_W'(column), loc_row);
        col_nxt = clnw_pkg::COL_W'(column);
        row_nxt = loc_row;
      end
      clnw_pkg::CMD_CLEAR: begin
        desc.main_wait = clnw_pkg::WAIT_CLEAR;
      end
      clnw_pkg::CMD_CHAR: begin
        desc.has_pre = wrap;
        if (char_code == clnw_pkg::CHAR_LF) begin
          desc.main_byte = clnw_pkg::addr_byte(c1, clnw_pkg::next_row(r1));
          col_nxt = c1;
          row_nxt = clnw_pkg::next_row(r1);
        end else if (char_code == clnw_pkg::CHAR_CR) begin
          desc.main_byte = clnw_pkg::addr_byte('0, r1);
          col_nxt = '0;
          row_nxt = r1;
        end else begin
          desc.main_byte = char_code;
          desc.main_rs   = 1'b1;
          col_nxt = c1 + clnw_pkg::COL_W'(1);
          row_nxt = r1;
        end
      end
      default: begin
        col_nxt = col_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= 1'b0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/clnw_queue.sv
`default_nettype none

module clnw_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire clnw_pkg::desc_t wr_data,
  output logic                 full,
  input  wire logic            rd_en,
  output clnw_pkg::desc_t      rd_data,
  output logic                 empty
);

  clnw_pkg::desc_t mem_r [clnw_pkg::QUEUE_DEPTH];

  logic [clnw_pkg::QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [clnw_pkg::QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [clnw_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == clnw_pkg::QCNT_W'(clnw_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wr_en ? wptr_r + clnw_pkg::QPTR_W'(1) : wptr_r;
    rptr_nxt = rd_en ? rptr_r + clnw_pkg::QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + clnw_pkg::QCNT_W'(1);
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - clnw_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/clnw_back.sv
`default_nettype none

module clnw_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire clnw_pkg::desc_t q_data,
  input  wire logic            q_empty,
  output logic                 q_pop,
  output logic [3:0]           nibble,
  output logic                 reg_select,
  output logic [4:0]           wait_ms,
  output logic                 last,
  output logic                 empty,
  input  wire logic            pop
);

  clnw_pkg::desc_t            cur_r;
  logic                       cur_valid_r, cur_valid_nxt;
  logic [clnw_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [3:0]                 nibble_r;
  logic                       rs_r;
  logic [4:0]                 wait_r;
  logic                       last_r;

  clnw_pkg::init_nib_t        init_nib;
  logic                       sel_pre;
  logic [7:0]                 cur_byte;
  logic [3:0]                 g_nibble;
  logic                       g_rs;
  logic [4:0]                 g_wait;
  logic                       g_last;
  logic [clnw_pkg::IDX_W-1:0] last_idx;
  logic                       advance;
  logic                       pop_acc;

  always_comb begin
    init_nib = clnw_pkg::init_nibble(idx_r);
    sel_pre  = cur_r.has_pre && (idx_r < clnw_pkg::IDX_W'(2));
    cur_byte = sel_pre ? cur_r.pre_byte : cur_r.main_byte;

    if (cur_r.is_init) begin
      last_idx = clnw_pkg::IDX_W'(clnw_pkg::INIT_NIBBLES - 1);
      g_nibble = init_nib.nibble;
      g_rs     = 1'b0;
      g_wait   = init_nib.wait_ms;
    end else begin
      last_idx = cur_r.has_pre ? clnw_pkg::IDX_W'(3) : clnw_pkg::IDX_W'(1);
      // Even positions carry the high nibble of a byte.
      g_nibble = idx_r[0] ? cur_byte[3:0] : cur_byte[7:4];
      g_rs     = sel_pre ? 1'b0 : cur_r.main_rs;
      g_wait   = (!sel_pre && idx_r[0]) ? cur_r.main_wait : clnw_pkg::WAIT_NONE;
    end
    g_last = (idx_r == last_idx);

    pop_acc = pop && out_valid_r;
    advance = cur_valid_r && (!out_valid_r || pop);

    out_valid_nxt = advance ? 1'b1 : (pop_acc ? 1'b0 : out_valid_r);

    idx_nxt       = idx_r;
    cur_valid_nxt = cur_valid_r;
    if (advance) begin
      idx_nxt = g_last ? '0 : idx_r + clnw_pkg::IDX_W'(1);
      if (g_last) begin
        cur_valid_nxt = 1'b0;
      end
    end

    // A new job is loaded as soon as the current one hands over its last nibble.
    q_pop = !q_empty && (!cur_valid_r || (advance && g_last));
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (advance) begin
      nibble_r <= g_nibble;
      rs_r     <= g_rs;
      wait_r   <= g_wait;
      last_r   <= g_last;
    end
  end

  assign nibble     = nibble_r;
  assign reg_select = rs_r;
  assign wait_ms    = wait_r;
  assign last       = last_r;
  assign empty      = !out_valid_r;

endmodule

`default_nettype wire

// File: rtl/char_lcd_nibble_writer_unit.sv
`default_nettype none

// Channel  Direction  Handshake           Payload
// in       input      in_push / in_full   in_command, in_column, in_row, in_char_code
// out      output     out_empty / out_pop out_nibble, out_reg_select, out_wait_ms, out_last
//
// The front end classifies each command in the cycle it arrives and tracks the cursor;
// it accepts a new transaction every cycle while its four-job queue has room.
// The back end sends one nibble per cycle while the consumer keeps popping: 2 for locate
// and clear, 2 to 4 for a character and 12 for init, so the nibble sequencer sets the
// sustained rate. The result register refills in the cycle it is popped. Synchronous
// reset homes the cursor and empties both the job queue and the result register.

module char_lcd_nibble_writer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [1:0] in_command,
  input  wire logic [3:0] in_column,
  input  wire logic       in_row,
  input  wire logic [7:0] in_char_code,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [3:0]      out_nibble,
  output logic            out_reg_select,
  output logic [4:0]      out_wait_ms,
  output logic            out_last
);

  clnw_pkg::desc_t desc;
  clnw_pkg::desc_t q_data;
  logic            accept;
  logic            q_empty;
  logic            q_pop;

  assign accept = in_push && !in_full;

  clnw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .command   (in_command),
    .column    (in_column),
    .row       (in_row),
    .char_code (in_char_code),
    .desc      (desc)
  );

  clnw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (desc),
    .full    (in_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  clnw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_data),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .nibble     (out_nibble),
    .reg_select (out_reg_select),
    .wait_ms    (out_wait_ms),
    .last       (out_last),
    .empty      (out_empty),
    .pop        (out_pop)
  );

endmodule

`default_nettype wire
